[hdl/lcd_number_text_formatter_top_macros.svh]
// Assertion helpers used by the formatter top level.
`ifndef LCD_NUMBER_TEXT_FORMATTER_TOP_MACROS_SVH
`define LCD_NUMBER_TEXT_FORMATTER_TOP_MACROS_SVH

// Property checked only while out of reset.
`define LNF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked at every edge, reset included.
`define LNF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hdl/lnf_pkg.sv]
`default_nettype none
package lnf_pkg;

    // request kinds
    localparam logic [2:0] CMD_CHAR = 3'd0;
    localparam logic [2:0] CMD_UDEC = 3'd1;
    localparam logic [2:0] CMD_SDEC = 3'd2;
    localparam logic [2:0] CMD_HEX  = 3'd3;
    localparam logic [2:0] CMD_BIN  = 3'd4;

    // digit radix of a queued job
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    // display bytes
    localparam logic [7:0] CURSOR_BASE = 8'h80;
    localparam logic [7:0] ROW2_OFFSET = 8'h40;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_PLUS     = 8'h2B;
    localparam logic [7:0] CH_MINUS    = 8'h2D;

    // queue between front and back
    localparam int FIFO_DEPTH = 2;

    // one classified request
    typedef struct packed {
        logic [7:0]  cursor;   // cursor command byte
        logic        pre_en;   // char or sign beat follows the cursor
        logic [7:0]  pre_byte;
        logic [1:0]  radix;
        logic [4:0]  count;    // digits to write, saturated
        logic [19:0] digits;   // BCD for decimal, raw value otherwise
    } job_t;

    // digit value to uppercase ASCII
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = CH_ZERO + {4'b0, d};
        end else begin
            r = CH_UPPER_A + {4'b0, d} - 8'd10;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/lnf_front.sv]
`default_nettype none
module lnf_front #(
    parameter int MAX_DIGITS = 16
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [39:0]         s_tdata,
    input  wire  [7:0]          s_tuser,
    output logic                push,
    output lnf_pkg::job_t       push_job,
    input  wire                 fifo_full
);
    localparam logic [4:0] MAX_CNT  = 5'(MAX_DIGITS);
    localparam logic [4:0] BIN_BITS = 5'd17;

    logic [2:0]  command;
    logic [1:0]  line;
    logic [5:0]  column;
    logic [15:0] value;
    logic [4:0]  digit_count;
    logic [7:0]  char_code;

    lnf_pkg::job_t job_in;
    logic [16:0]   mag;
    logic          is_dec;

    logic          busy_reg, busy_next;
    logic [4:0]    steps_reg, steps_next;
    lnf_pkg::job_t job_reg, job_next;
    logic [16:0]   bin_reg, bin_next;
    logic [19:0]   adj;

    // unpack the beat
    assign command     = s_tuser[2:0];
    assign line        = s_tdata[1:0];
    assign column      = s_tdata[7:2];
    assign value       = s_tdata[23:8];
    assign digit_count = s_tdata[28:24];
    assign char_code   = s_tdata[36:29];

    assign s_tready = !busy_reg;
    assign push     = busy_reg && (steps_reg == 5'd0) && !fifo_full;
    assign push_job = job_reg;

    // classify the request
    always_comb begin
        job_in.cursor = lnf_pkg::CURSOR_BASE |
            ({2'b0, column} + 8'hFF + ((line != 2'd1) ? lnf_pkg::ROW2_OFFSET : 8'h00));
        job_in.pre_en   = 1'b0;
        job_in.pre_byte = char_code;
        job_in.radix    = lnf_pkg::RADIX_DEC;
        job_in.count    = (digit_count > MAX_CNT) ? MAX_CNT : digit_count;
        job_in.digits   = {4'b0, value};
        mag             = {1'b0, value};
        is_dec          = 1'b0;
        unique case (command)
            lnf_pkg::CMD_CHAR: begin
                job_in.pre_en = 1'b1;
                job_in.count  = 5'd0;
            end
            lnf_pkg::CMD_UDEC: begin
                is_dec        = 1'b1;
                job_in.digits = 20'd0;
            end
            lnf_pkg::CMD_SDEC: begin
                is_dec          = 1'b1;
                job_in.digits   = 20'd0;
                job_in.pre_en   = 1'b1;
                job_in.pre_byte = value[15] ? lnf_pkg::CH_MINUS : lnf_pkg::CH_PLUS;
                mag             = value[15] ? (17'h10000 - {1'b0, value}) : {1'b0, value};
            end
            lnf_pkg::CMD_HEX: job_in.radix = lnf_pkg::RADIX_HEX;
            lnf_pkg::CMD_BIN: job_in.radix = lnf_pkg::RADIX_BIN;
            default: job_in.count = 5'd0;
        endcase
    end

    // double-dabble adjust of the BCD digits
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            adj[i*4 +: 4] = (job_reg.digits[i*4 +: 4] >= 4'd5) ?
                            job_reg.digits[i*4 +: 4] + 4'd3 : job_reg.digits[i*4 +: 4];
        end
    end

    // request register and conversion sequencing
    always_comb begin
        busy_next  = busy_reg;
        steps_next = steps_reg;
        job_next   = job_reg;
        bin_next   = bin_reg;
        if (s_tvalid && s_tready) begin
            busy_next  = 1'b1;
            steps_next = is_dec ? BIN_BITS : 5'd0;
            job_next   = job_in;
            bin_next   = mag;
        end else if (busy_reg && steps_reg != 5'd0) begin
            steps_next      = steps_reg - 5'd1;
            job_next.digits = {adj[18:0], bin_reg[16]};
            bin_next        = {bin_reg[15:0], 1'b0};
        end else if (push) begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            steps_reg <= 5'd0;
        end else begin
            busy_reg  <= busy_next;
            steps_reg <= steps_next;
        end
        job_reg <= job_next;
        bin_reg <= bin_next;
    end
endmodule
`default_nettype wire

[hdl/lnf_fifo.sv]
`default_nettype none
module lnf_fifo (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            push,
    input  lnf_pkg::job_t  push_job,
    output logic           full,
    input  wire            pop,
    output lnf_pkg::job_t  pop_job,
    output logic           empty
);
    localparam int D  = lnf_pkg::FIFO_DEPTH;
    localparam int PW = (D > 1) ? $clog2(D) : 1;
    localparam int CW = $clog2(D + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(D - 1);

    lnf_pkg::job_t   mem [D];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [CW-1:0]   cnt_reg;

    assign full    = (cnt_reg == CW'(D));
    assign empty   = (cnt_reg == '0);
    assign pop_job = mem[rptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == LAST_PTR) ? '0 : wptr_reg + PW'(1);
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == LAST_PTR) ? '0 : rptr_reg + PW'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end
endmodule
`default_nettype wire

[hdl/lnf_back.sv]
`default_nettype none
module lnf_back (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            fifo_empty,
    input  lnf_pkg::job_t  pop_job,
    output logic           pop,
    output logic           m_tvalid,
    input  wire            m_tready,
    output logic [7:0]     m_tdata,
    output logic [7:0]     m_tuser,
    output logic           m_tlast
);
    localparam logic [1:0] PH_CUR = 2'd0;
    localparam logic [1:0] PH_PRE = 2'd1;
    localparam logic [1:0] PH_DIG = 2'd2;

    lnf_pkg::job_t job_reg;
    logic          active_reg, active_next;
    logic [1:0]    phase_reg, phase_next;
    logic [3:0]    pos_reg, pos_next;
    logic          vld_reg;
    logic [7:0]    byte_reg;
    logic          rs_reg, last_reg;

    logic          slot_free;
    logic [7:0]    beat_byte;
    logic          beat_rs, beat_last;
    logic [3:0]    digit;
    logic [31:0]   dec_pad;
    logic [15:0]   raw_val;
    logic [3:0]    first_pos;

    assign slot_free = !vld_reg || m_tready;
    assign pop       = !active_reg && !fifo_empty;
    assign dec_pad   = {12'b0, job_reg.digits};
    assign raw_val   = job_reg.digits[15:0];
    assign first_pos = job_reg.count[3:0] - 4'd1;

    assign m_tvalid = vld_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = {7'b0, rs_reg};
    assign m_tlast  = last_reg;

    // digit at the current position, zero above the value's width
    always_comb begin
        digit = 4'd0;
        unique case (job_reg.radix)
            lnf_pkg::RADIX_DEC: if (pos_reg < 4'd5) digit = dec_pad[pos_reg[2:0]*4 +: 4];
            lnf_pkg::RADIX_HEX: if (pos_reg < 4'd4) digit = raw_val[pos_reg[1:0]*4 +: 4];
            lnf_pkg::RADIX_BIN: digit = {3'b0, raw_val[pos_reg]};
            default:            digit = 4'd0;
        endcase
    end

    // beat for the current phase and where to go next
    always_comb begin
        beat_byte   = job_reg.cursor;
        beat_rs     = 1'b0;
        beat_last   = 1'b0;
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        active_next = active_reg;
        unique case (phase_reg)
            PH_CUR: begin
                beat_last = !job_reg.pre_en && (job_reg.count == 5'd0);
                if (job_reg.pre_en) begin
                    phase_next = PH_PRE;
                end else begin
                    phase_next = PH_DIG;
                    pos_next   = first_pos;
                end
            end
            PH_PRE: begin
                beat_byte  = job_reg.pre_byte;
                beat_rs    = 1'b1;
                beat_last  = (job_reg.count == 5'd0);
                phase_next = PH_DIG;
                pos_next   = first_pos;
            end
            PH_DIG: begin
                beat_byte = lnf_pkg::digit_char(digit);
                beat_rs   = 1'b1;
                beat_last = (pos_reg == 4'd0);
                pos_next  = pos_reg - 4'd1;
            end
            default: begin
                beat_last = 1'b1;
            end
        endcase
        if (beat_last) begin
            active_next = 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            phase_reg  <= PH_CUR;
            pos_reg    <= 4'd0;
        end else if (pop) begin
            active_reg <= 1'b1;
            phase_reg  <= PH_CUR;
        end else if (active_reg && slot_free) begin
            active_reg <= active_next;
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= pop_job;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (slot_free) begin
            vld_reg <= active_reg;
        end
        if (slot_free && active_reg) begin
            byte_reg <= beat_byte;
            rs_reg   <= beat_rs;
            last_reg <= beat_last;
        end
    end
endmodule
`default_nettype wire

[hdl/lcd_number_text_formatter_top.sv]
// Character display writer: turns one request into a run of display bus writes.
// Input s_*: one request per beat. s_tuser[2:0] is the mode (char, unsigned
// decimal, signed decimal, hex, binary); s_tdata carries line, column, value,
// digit count and character. Output m_*: one bus write per beat, m_tuser[0] is
// the register select (0 command, 1 data), m_tdata the byte, m_tlast closes the
// run of a request. Every run starts with the cursor command, then an optional
// character or sign beat, then up to MAX_DIGITS digits, most significant first.
// The front takes a request in one beat; decimal modes then pass through the
// bit-serial BCD converter before the job enters a two-entry queue. The back
// emits one write per cycle while m_tready allows and loads each job from the
// queue before its first write, so it cannot start a new request before the
// last write of the previous one. A stall on m_tready holds the output
// register. s_tready is low from each accept until the front hands the request
// to the queue; with two requests waiting in the queue the front keeps its
// request and s_tready stays low until the back frees a slot.
// Reset (aresetn low, synchronous) empties the queue and clears all handshakes.
`default_nettype none
`include "lcd_number_text_formatter_top_macros.svh"
module lcd_number_text_formatter_top #(
    parameter int MAX_DIGITS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // line[1:0], column[7:2], value[23:8], digit_count[28:24], char_code[36:29]
    input  wire  [39:0] s_tdata,
    // command[2:0]
    input  wire  [7:0]  s_tuser,
    output logic        m_tvalid,
    input  wire         m_tready,
    // bus_byte[7:0]
    output logic [7:0]  m_tdata,
    // reg_select[0]
    output logic [7:0]  m_tuser,
    output logic        m_tlast
);
    logic          fifo_push, fifo_pop, fifo_full, fifo_empty;
    lnf_pkg::job_t push_job, pop_job;

    lnf_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .push      (fifo_push),
        .push_job  (push_job),
        .fifo_full (fifo_full)
    );

    lnf_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fifo_push),
        .push_job (push_job),
        .full     (fifo_full),
        .pop      (fifo_pop),
        .pop_job  (pop_job),
        .empty    (fifo_empty)
    );

    lnf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .pop_job    (pop_job),
        .pop        (fifo_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // checks
    `LNF_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "output valid after reset")
    `LNF_ASSERT(a_no_overflow, !(fifo_push && fifo_full), "queue push while full")
    `LNF_ASSERT(a_no_underflow, !(fifo_pop && fifo_empty), "queue pop while empty")
endmodule
`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;

    localparam int MAX_DIGITS  = 16;
    localparam int RUN_LATENCY = 40;   // cycles past the last beat before the end check
    localparam int LONG_HOLD   = 400;  // receiver hold-off for the backpressure test
    localparam int RAND_ITEMS  = 80;
    localparam int QUIET_ITEMS = 25;   // tail of the random part with no idling

    // modes outside the defined set
    localparam logic [2:0] CMD_RSVD5 = 3'd5;
    localparam logic [2:0] CMD_RSVD6 = 3'd6;
    localparam logic [2:0] CMD_RSVD7 = 3'd7;

    // one display bus write
    typedef struct packed {
        logic       reg_select;
        logic [7:0] bus_byte;
        logic       last;
    } lcd_write_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [39:0] s_tdata  = '0;
    logic [7:0]  s_tuser  = '0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [7:0]  m_tdata;
    wire  [7:0]  m_tuser;
    wire         m_tlast;

    lcd_write_t display_writes[$];   // writes still due from the block
    int         error_count   = 0;
    bit         tx_idle_en    = 1'b0;
    bit         rx_idle_en    = 1'b0;
    bit         long_hold_req = 1'b0;
    int         rx_hold       = 0;

    lcd_number_text_formatter_top #(
        .MAX_DIGITS(MAX_DIGITS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Expected write run for one request: cursor, optional char/sign, digits.
    task automatic predict_writes(input logic [2:0] cmd, input logic [1:0] row_sel,
                                  input logic [5:0] col, input logic [15:0] val,
                                  input logic [4:0] cnt, input logic [7:0] ch);
        lcd_write_t run[MAX_DIGITS + 2];
        logic [3:0] digs[MAX_DIGITS];
        logic [7:0] addr;
        int n;
        int k;
        int i;
        int radix;
        int mag;
        begin
            n = (cnt > MAX_DIGITS) ? MAX_DIGITS : int'(cnt);
            k = 0;
            radix = 0;
            mag = int'(val);
            addr = {2'b00, col} - 8'd1;
            if (row_sel != 2'd1) begin
                addr = addr + lnf_pkg::ROW2_OFFSET;
            end
            run[k] = '{reg_select: 1'b0, bus_byte: lnf_pkg::CURSOR_BASE | addr, last: 1'b0};
            k++;
            case (cmd)
                lnf_pkg::CMD_CHAR: begin
                    run[k] = '{reg_select: 1'b1, bus_byte: ch, last: 1'b0};
                    k++;
                end
                lnf_pkg::CMD_UDEC: radix = 10;
                lnf_pkg::CMD_SDEC: begin
                    radix = 10;
                    if (val[15]) begin
                        run[k] = '{reg_select: 1'b1, bus_byte: lnf_pkg::CH_MINUS, last: 1'b0};
                        mag = 32'h10000 - int'(val);
                    end else begin
                        run[k] = '{reg_select: 1'b1, bus_byte: lnf_pkg::CH_PLUS, last: 1'b0};
                    end
                    k++;
                end
                lnf_pkg::CMD_HEX: radix = 16;
                lnf_pkg::CMD_BIN: radix = 2;
                default: radix = 0;
            endcase
            // digits, least significant first, then emitted in reverse
            if (radix != 0) begin
                for (i = 0; i < n; i++) begin
                    digs[i] = 4'(mag % radix);
                    mag = mag / radix;
                end
                for (i = n - 1; i >= 0; i--) begin
                    run[k].reg_select = 1'b1;
                    run[k].bus_byte = (digs[i] < 4'd10)
                                    ? lnf_pkg::CH_ZERO + {4'b0, digs[i]}
                                    : lnf_pkg::CH_UPPER_A + {4'b0, digs[i]} - 8'd10;
                    run[k].last = 1'b0;
                    k++;
                end
            end
            run[k - 1].last = 1'b1;
            for (i = 0; i < k; i++) begin
                display_writes.push_back(run[i]);
            end
        end
    endtask

    // Offer one request; returns at the falling edge after it is accepted.
    task automatic send_request(input logic [2:0] cmd, input logic [1:0] row_sel,
                                input logic [5:0] col, input logic [15:0] val,
                                input logic [4:0] cnt, input logic [7:0] ch);
        begin
            if (tx_idle_en && $urandom_range(0, 3) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= {3'b000, ch, cnt, val, col, row_sel};
            s_tuser  <= {5'b00000, cmd};
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            predict_writes(cmd, row_sel, col, val, cnt, ch);
            @(negedge aclk);
        end
    endtask

    // Stop offering and wait until every expected write has come out.
    task automatic drain_writes;
        begin
            s_tvalid <= 1'b0;
            while (display_writes.size() != 0) @(posedge aclk);
            repeat (RUN_LATENCY) @(posedge aclk);
            @(negedge aclk);
        end
    endtask

    // Receiver: random stall bursts, plus one long hold on request
    always @(negedge aclk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            rx_hold = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            rx_hold = $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each output beat with the oldest expected write
    always @(posedge aclk) begin
        lcd_write_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (display_writes.size() == 0) begin
                $error("unexpected beat: reg_select=%0d bus_byte=%02h last=%0d",
                       m_tuser[0], m_tdata, m_tlast);
                error_count++;
            end else begin
                exp_w = display_writes.pop_front();
                if (m_tuser[0] !== exp_w.reg_select) begin
                    $error("reg_select: expected %0d, got %0d", exp_w.reg_select, m_tuser[0]);
                    error_count++;
                end
                if (m_tdata !== exp_w.bus_byte) begin
                    $error("bus_byte: expected %02h, got %02h", exp_w.bus_byte, m_tdata);
                    error_count++;
                end
                if (m_tlast !== exp_w.last) begin
                    $error("last: expected %0d, got %0d", exp_w.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Cursor addressing on both rows, odd line codes, column wrap, char extremes
    task automatic test_cursor_and_char;
        begin
            send_request(lnf_pkg::CMD_CHAR, 2'd1, 6'd1,  16'h0000, 5'd0, 8'h00);
            send_request(lnf_pkg::CMD_CHAR, 2'd2, 6'd40, 16'hFFFF, 5'd31, 8'hFF);
            send_request(lnf_pkg::CMD_CHAR, 2'd0, 6'd0,  16'h1234, 5'd3, 8'h41);
            send_request(lnf_pkg::CMD_CHAR, 2'd3, 6'd63, 16'h0000, 5'd0, 8'h7E);
            send_request(lnf_pkg::CMD_CHAR, 2'd1, 6'd0,  16'h0000, 5'd0, 8'hA5);
        end
    endtask

    // Decimal modes: zero and full counts, saturation, sign corners
    task automatic test_decimal;
        begin
            send_request(lnf_pkg::CMD_UDEC, 2'd1, 6'd5,  16'd0,     5'd0,  8'h00);
            send_request(lnf_pkg::CMD_UDEC, 2'd2, 6'd1,  16'd65535, 5'd5,  8'h00);
            send_request(lnf_pkg::CMD_UDEC, 2'd1, 6'd20, 16'd65535, 5'd16, 8'hFF);
            send_request(lnf_pkg::CMD_UDEC, 2'd1, 6'd3,  16'd12345, 5'd31, 8'h00);
            send_request(lnf_pkg::CMD_SDEC, 2'd2, 6'd7,  16'h7FFF,  5'd5,  8'h00);
            send_request(lnf_pkg::CMD_SDEC, 2'd1, 6'd8,  16'h8000,  5'd6,  8'h00);
            send_request(lnf_pkg::CMD_SDEC, 2'd1, 6'd9,  16'hFFFF,  5'd3,  8'h00);
            send_request(lnf_pkg::CMD_SDEC, 2'd2, 6'd10, 16'h0000,  5'd0,  8'h00);
            send_request(lnf_pkg::CMD_SDEC, 2'd1, 6'd2,  16'h8001,  5'd17, 8'h00);
        end
    endtask

    // Hex and binary, including the full 16-position runs
    task automatic test_hex_and_binary;
        begin
            send_request(lnf_pkg::CMD_HEX, 2'd1, 6'd1,  16'hFFFF, 5'd4,  8'h00);
            send_request(lnf_pkg::CMD_HEX, 2'd2, 6'd33, 16'hABCD, 5'd16, 8'h00);
            send_request(lnf_pkg::CMD_HEX, 2'd1, 6'd1,  16'h0000, 5'd0,  8'h00);
            send_request(lnf_pkg::CMD_BIN, 2'd1, 6'd1,  16'hA5A5, 5'd16, 8'h00);
            send_request(lnf_pkg::CMD_BIN, 2'd2, 6'd40, 16'hFFFF, 5'd1,  8'h00);
            send_request(lnf_pkg::CMD_BIN, 2'd0, 6'd12, 16'h8000, 5'd31, 8'h00);
        end
    endtask

    // Modes outside the set write only the cursor
    task automatic test_unknown_mode;
        begin
            send_request(CMD_RSVD5, 2'd1, 6'd4,  16'hFFFF, 5'd16, 8'hFF);
            send_request(CMD_RSVD6, 2'd2, 6'd0,  16'h0000, 5'd31, 8'h00);
            send_request(CMD_RSVD7, 2'd3, 6'd63, 16'h5A5A, 5'd8,  8'h33);
        end
    endtask

    task automatic send_random_request;
        logic [2:0]  cmd;
        logic [5:0]  col;
        logic [15:0] val;
        logic [4:0]  cnt;
        int pick;
        begin
            pick = $urandom_range(0, 9);
            cmd = (pick < 9) ? 3'(pick % 5) : 3'($urandom_range(5, 7));
            col = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(1, 40));
            val = 16'($urandom);
            if ($urandom_range(0, 7) == 0) begin
                case ($urandom_range(0, 3))
                    0: val = 16'h0000;
                    1: val = 16'hFFFF;
                    2: val = 16'h8000;
                    default: val = 16'h7FFF;
                endcase
            end
            cnt = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                              : 5'($urandom_range(0, 16));
            send_request(cmd, 2'($urandom_range(0, 3)), col, val, cnt, 8'($urandom));
        end
    endtask

    // Receiver holds off long while requests keep coming, so the queue fills
    task automatic test_backpressure;
        int i;
        begin
            @(posedge aclk);
            long_hold_req = 1'b1;
            @(negedge aclk);
            for (i = 0; i < 8; i++) begin
                send_request(lnf_pkg::CMD_SDEC, 2'($urandom_range(0, 3)),
                             6'($urandom_range(1, 40)), 16'($urandom), 5'd16, 8'($urandom));
            end
            drain_writes();
        end
    endtask

    // Random traffic with idling on both sides, then a quiet tail
    task automatic test_random_traffic;
        int i;
        begin
            tx_idle_en = 1'b1;
            rx_idle_en = 1'b1;
            for (i = 0; i < RAND_ITEMS; i++) begin
                if (i == RAND_ITEMS - QUIET_ITEMS) begin
                    tx_idle_en = 1'b0;
                    rx_idle_en = 1'b0;
                end
                if (i == RAND_ITEMS / 2) begin
                    drain_writes();
                end
                send_random_request();
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_cursor_and_char();
        test_decimal();
        test_hex_and_binary();
        test_unknown_mode();
        drain_writes();
        test_backpressure();
        test_random_traffic();
        drain_writes();
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
